FILE: rtl/core/tcw_pkg.sv
// Shared types, opcodes and constants of the text console writer.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Cell contents
    localparam logic [7:0]  ATTR_BYTE    = 8'h07;
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [15:0] BLANK_CELL   = {ATTR_BYTE, BLANK_CHAR};
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;

    // Opcodes
    localparam logic [2:0] OP_PUT_CHAR     = 3'd0;
    localparam logic [2:0] OP_CLEAR        = 3'd1;
    localparam logic [2:0] OP_INIT         = 3'd2;
    localparam logic [2:0] OP_PLACE_CURSOR = 3'd3;
    localparam logic [2:0] OP_READ         = 3'd4;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [6:0] column_in;
        logic [4:0] row_in;
    } tcw_req_t;

    typedef struct packed {
        logic [15:0] cell_word;
        logic [10:0] cursor_position;
        logic        cursor_report;
    } tcw_rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_req;
        logic clear_step;
        logic home;
        logic put_exec;
        logic place_cursor;
        logic read_issue;
        logic scroll_read;
        logic scroll_write;
        logic load_result;
    } tcw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       early_put;
        logic       sweep_last;
        logic       scroll_due;
        logic       rsp_free;
    } tcw_status_t;

endpackage

FILE: rtl/core/tcw_controller.sv
// Sequencing state machine of the text console writer.
module tcw_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);
    import tcw_pkg::*;

    typedef enum logic [7:0] {
        S_BOOT      = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_EXEC      = 8'b0000_0100,
        S_CLEAR     = 8'b0000_1000,
        S_PUT       = 8'b0001_0000,
        S_SCROLL_RD = 8'b0010_0000,
        S_SCROLL_WR = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE) || ((state_reg == S_FINISH) && status.rsp_free);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.latch_req = req_valid && req_ready;
        unique case (state_reg)
            S_BOOT:
            begin
                cmd.clear_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (status.opcode)
                    OP_PUT_CHAR:
                    begin
                        state_next = status.early_put ? S_CLEAR : S_PUT;
                    end
                    OP_CLEAR, OP_INIT:
                    begin
                        cmd.home   = 1'b1;
                        state_next = S_CLEAR;
                    end
                    OP_PLACE_CURSOR:
                    begin
                        cmd.place_cursor = 1'b1;
                        state_next       = S_FINISH;
                    end
                    OP_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = (status.opcode == OP_PUT_CHAR) ? S_PUT : S_FINISH;
                end
            end
            S_PUT:
            begin
                cmd.put_exec = 1'b1;
                state_next   = status.scroll_due ? S_SCROLL_RD : S_FINISH;
            end
            S_SCROLL_RD:
            begin
                cmd.scroll_read = 1'b1;
                state_next      = S_SCROLL_WR;
            end
            S_SCROLL_WR:
            begin
                cmd.scroll_write = 1'b1;
                state_next       = status.sweep_last ? S_FINISH : S_SCROLL_RD;
            end
            S_FINISH:
            begin
                if (status.rsp_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = req_valid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request did not start execution");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> status.rsp_free)
        else $error("result loaded over an untaken response");

    a_boot_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BOOT) && status.sweep_last) |=> (state_reg == S_IDLE))
        else $error("boot clearing pass did not end in idle");

endmodule

FILE: rtl/core/tcw_datapath.sv
// Cell store, cursor, sweep counter and response register of the text console writer.
module tcw_datapath
#(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::tcw_cmd_t    cmd,
    input  tcw_pkg::tcw_req_t    req,
    output tcw_pkg::tcw_status_t status,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output tcw_pkg::tcw_rsp_t    rsp
);
    import tcw_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COPY_CELLS = COLUMNS * (ROWS - 1);
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);

    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LIMIT = AW'(COPY_CELLS);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

    function automatic logic [AW-1:0] cell_index(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        cell_index = AW'(r) * COLS_A + AW'(c);
    endfunction

    logic [15:0] cell_mem [CELLS];
    logic [15:0] rdata_reg;

    tcw_req_t      req_reg;
    tcw_rsp_t      rsp_reg;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          init_reg;
    logic          init_next;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;

    logic [8:0]    col_wide;
    logic [7:0]    row_wide;
    logic [CW-1:0] sat_col;
    logic [RW-1:0] sat_row;
    logic          is_newline;
    logic          wrap;
    logic          scroll_due;
    logic [CW-1:0] put_col;
    logic [RW-1:0] put_row;
    logic [AW-1:0] cursor_idx;
    logic          copy_region;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          report;

    // Coordinates from the request, held to the screen
    assign col_wide = 9'(req_reg.column_in);
    assign row_wide = 8'(req_reg.row_in);
    assign sat_col  = (col_wide >= 9'(COLUMNS)) ? LAST_COL : col_wide[CW-1:0];
    assign sat_row  = (row_wide >= 8'(ROWS)) ? LAST_ROW : row_wide[RW-1:0];

    // Cursor advance for put_char
    assign is_newline = (req_reg.char_code == NEWLINE_CODE);
    assign wrap       = is_newline || (col_reg == LAST_COL);
    assign scroll_due = wrap && (row_reg == LAST_ROW);
    assign put_col    = wrap ? '0 : col_reg + CW'(1);
    assign put_row    = (wrap && !scroll_due) ? row_reg + RW'(1) : row_reg;

    assign cursor_idx  = cell_index(row_reg, col_reg);
    assign copy_region = (sweep_reg < COPY_LIMIT);

    // Store port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = BLANK_CELL;
        priority if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.scroll_write)
        begin
            mem_we    = 1'b1;
            mem_wdata = copy_region ? rdata_reg : BLANK_CELL;
        end
        else if (cmd.put_exec && !is_newline)
        begin
            mem_we    = 1'b1;
            mem_waddr = cursor_idx;
            mem_wdata = {ATTR_BYTE, req_reg.char_code};
        end
    end

    assign mem_re    = cmd.read_issue || (cmd.scroll_read && copy_region);
    assign mem_raddr = cmd.read_issue ? cell_index(sat_row, sat_col) : sweep_reg + COLS_A;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= cell_mem[mem_raddr];
        end
    end

    always_comb
    begin
        unique case (req_reg.opcode)
            OP_PUT_CHAR, OP_CLEAR, OP_INIT, OP_PLACE_CURSOR: report = init_reg;
            default:                                         report = 1'b0;
        endcase
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cmd.home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.place_cursor)
        begin
            col_next = sat_col;
            row_next = sat_row;
        end
        else if (cmd.put_exec)
        begin
            col_next = put_col;
            row_next = put_row;
        end

        sweep_next = sweep_reg;
        if (cmd.clear_step || cmd.scroll_write)
        begin
            sweep_next = (sweep_reg == LAST_CELL) ? '0 : sweep_reg + AW'(1);
        end

        init_next = init_reg || (cmd.load_result && (req_reg.opcode == OP_INIT));

        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (cmd.load_result)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            init_reg      <= 1'b0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            init_reg      <= init_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg <= req;
        end
        if (cmd.load_result)
        begin
            rsp_reg.cell_word       <= (req_reg.opcode == OP_READ) ? rdata_reg : 16'h0000;
            rsp_reg.cursor_position <= 11'(cursor_idx);
            rsp_reg.cursor_report   <= report;
        end
    end

    assign status.opcode     = req_reg.opcode;
    assign status.early_put  = (req_reg.opcode == OP_PUT_CHAR) && (col_reg == '0)
                               && (row_reg == '0) && !init_reg;
    assign status.sweep_last = (sweep_reg == LAST_CELL);
    assign status.scroll_due = scroll_due;
    assign status.rsp_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS))
        else $error("cursor left the screen");

    a_scroll_keeps_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_exec && scroll_due) |=> ((row_reg == LAST_ROW) && (col_reg == '0)))
        else $error("scroll did not leave cursor at start of last row");

    a_load_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> rsp_valid_reg)
        else $error("loaded result not presented");

endmodule

FILE: rtl/core/text_console_writer_unit.sv
// Top level of the text console writer: controller joined to the cell store datapath.
// Steps from request accept to response valid: cursor moves, reads and unknown opcodes go
// from decode to loading the result; put_char writes the cell, then scrolls the store if the
// cursor wraps off the last row; clear and init sweep all COLUMNS*ROWS cells; a put_char that
// blanks the store first sweeps it before the write. The next request is taken as a result is
// loaded. Reset: cursor home, console not initialised; a clearing pass over all COLUMNS*ROWS
// cells (2000 at 80x25) blanks the store while no request is taken.
module text_console_writer_unit
#(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tcw_pkg::tcw_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tcw_pkg::tcw_rsp_t rsp
);
    import tcw_pkg::*;

    // Command and status buses between the two halves
    tcw_cmd_t    cmd;
    tcw_status_t status;

    // Sequence each request: decode, clear or scroll the store where the opcode needs it, load the response
    tcw_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the cells, cursor and response register; the response register
    // parts the two sides so a finished result may wait for rsp_ready
    tcw_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
